/* rtl/slbc_pkg.sv */
// shared types and constants for the status led blink controller
// no dependencies; imported by slbc_activity, slbc_led_sequencer and the top level
package slbc_pkg;

  localparam int TIME_WIDTH_DEF   = 32;
  localparam int WINDOW_WIDTH     = 16;
  localparam int MODE_WIDTH       = 4;
  localparam int CFG_INDEX_WIDTH  = 1;
  localparam int CFG_DATA_WIDTH   = WINDOW_WIDTH;
  localparam int NUM_SATS         = 3;

  localparam logic [WINDOW_WIDTH-1:0] ACTIVITY_WINDOW_RESET = WINDOW_WIDTH'(100);

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVITY_WINDOW = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RECEIVE_ONLY    = 1'b1;

  // flight modes, anything above MODE_CUSTOM2 shows as off
  localparam logic [MODE_WIDTH-1:0] MODE_OFF       = MODE_WIDTH'(0);
  localparam logic [MODE_WIDTH-1:0] MODE_NORMAL    = MODE_WIDTH'(1);
  localparam logic [MODE_WIDTH-1:0] MODE_AUTOLEVEL = MODE_WIDTH'(2);
  localparam logic [MODE_WIDTH-1:0] MODE_TRAINER   = MODE_WIDTH'(3);
  localparam logic [MODE_WIDTH-1:0] MODE_ATT_LOCK  = MODE_WIDTH'(4);
  localparam logic [MODE_WIDTH-1:0] MODE_LAUNCH    = MODE_WIDTH'(5);
  localparam logic [MODE_WIDTH-1:0] MODE_ANGLE     = MODE_WIDTH'(6);
  localparam logic [MODE_WIDTH-1:0] MODE_CUSTOM1   = MODE_WIDTH'(7);
  localparam logic [MODE_WIDTH-1:0] MODE_CUSTOM2   = MODE_WIDTH'(8);

  // led blink patterns
  typedef enum logic [2:0] {
    PAT_OFF, PAT_ON, PAT_SLOW_A, PAT_SLOW_B, PAT_FAST_A, PAT_FAST_B
  } pat_t;

  // per-tick control handed to the led sequencer
  typedef struct packed {
    logic                  any_active;
    logic [MODE_WIDTH-1:0] mode;
    logic                  binding;
    logic                  imu_ready;
    logic                  receive_only;
  } tick_ctl_t;

  // what the sequencer returns for the tick
  typedef struct packed {
    logic led_a;
    logic led_b;
    logic request;
    logic failsafe;
  } led_result_t;

endpackage

/* rtl/slbc_activity.sv */
// one satellite activity check: wrapped receive age against the window
// depends on slbc_pkg
module slbc_activity #(
  parameter int TIME_WIDTH = slbc_pkg::TIME_WIDTH_DEF
) (
  input  logic [TIME_WIDTH-1:0]             now,
  input  logic [TIME_WIDTH-1:0]             last,
  input  logic [slbc_pkg::WINDOW_WIDTH-1:0] window,
  output logic                              active
);
  import slbc_pkg::*;

  logic [TIME_WIDTH-1:0] age;

  // subtraction wraps modulo 2^TIME_WIDTH
  assign age    = now - last;
  assign active = (age < TIME_WIDTH'(window));

endmodule

/* rtl/slbc_led_sequencer.sv */
// failsafe flag, blink phase and status led levels, advanced once per item
// depends on slbc_pkg
module slbc_led_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  slbc_pkg::tick_ctl_t   ctl,
  output slbc_pkg::led_result_t result
);
  import slbc_pkg::*;

  localparam int PHASE_WIDTH = 5;
  localparam logic [PHASE_WIDTH-1:0] PHASE_LAST = PHASE_WIDTH'(19);
  localparam logic [PHASE_WIDTH-1:0] SLOW_EDGE  = PHASE_WIDTH'(10);

  logic [PHASE_WIDTH-1:0] blink_phase;
  logic [PHASE_WIDTH-1:0] blink_phase_next;
  logic                   led_a_level;
  logic                   led_b_level;
  logic                   failsafe_flag;
  logic                   failsafe_flag_next;
  logic                   request;
  pat_t                   pat_a;
  pat_t                   pat_b;

  function automatic pat_t mode_pat_a(input logic [MODE_WIDTH-1:0] mode);
    pat_t p;
    unique case (mode)
      MODE_AUTOLEVEL, MODE_ATT_LOCK, MODE_CUSTOM1: p = PAT_ON;
      MODE_TRAINER, MODE_CUSTOM2:                  p = PAT_FAST_A;
      default:                                     p = PAT_OFF;
    endcase
    return p;
  endfunction

  function automatic pat_t mode_pat_b(input logic [MODE_WIDTH-1:0] mode);
    pat_t p;
    unique case (mode)
      MODE_NORMAL, MODE_ATT_LOCK, MODE_CUSTOM2: p = PAT_ON;
      MODE_LAUNCH, MODE_CUSTOM1:                p = PAT_FAST_A;
      MODE_ANGLE:                               p = PAT_SLOW_A;
      default:                                  p = PAT_OFF;
    endcase
    return p;
  endfunction

  function automatic logic apply_pattern(input pat_t pat, input logic level,
                                         input logic [PHASE_WIDTH-1:0] phase);
    logic l;
    unique case (pat)
      PAT_ON:     l = 1'b1;
      PAT_SLOW_A: begin
        if (phase == '0) l = 1'b0;
        else if (phase == SLOW_EDGE) l = 1'b1;
        else l = level;
      end
      PAT_SLOW_B: begin
        if (phase == '0) l = 1'b1;
        else if (phase == SLOW_EDGE) l = 1'b0;
        else l = level;
      end
      PAT_FAST_A: l = phase[0];
      PAT_FAST_B: l = ~phase[0];
      default:    l = 1'b0;
    endcase
    return l;
  endfunction

  always_comb begin
    failsafe_flag_next = failsafe_flag;
    request            = 1'b0;
    if (ctl.any_active) begin
      failsafe_flag_next = 1'b0;
    end else if (!failsafe_flag) begin
      failsafe_flag_next = 1'b1;
      request            = 1'b1;
    end
  end

  // overrides: binding, then imu not ready (unless receive only), then failsafe
  always_comb begin
    priority if (ctl.binding) begin
      pat_a = PAT_FAST_A;
      pat_b = PAT_FAST_B;
    end else if (!ctl.imu_ready && !ctl.receive_only) begin
      pat_a = PAT_FAST_A;
      pat_b = PAT_FAST_A;
    end else if (failsafe_flag_next) begin
      pat_a = PAT_SLOW_B;
      pat_b = PAT_SLOW_A;
    end else begin
      pat_a = mode_pat_a(ctl.mode);
      pat_b = mode_pat_b(ctl.mode);
    end
  end

  assign blink_phase_next = (blink_phase >= PHASE_LAST) ? '0 : blink_phase + 1'b1;

  assign result.led_a    = apply_pattern(pat_a, led_a_level, blink_phase);
  assign result.led_b    = apply_pattern(pat_b, led_b_level, blink_phase);
  assign result.request  = request;
  assign result.failsafe = failsafe_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_phase   <= '0;
      led_a_level   <= 1'b0;
      led_b_level   <= 1'b0;
      failsafe_flag <= 1'b0;
    end else if (advance) begin
      blink_phase   <= blink_phase_next;
      led_a_level   <= result.led_a;
      led_b_level   <= result.led_b;
      failsafe_flag <= failsafe_flag_next;
    end
  end

endmodule

/* rtl/status_led_blink_controller.sv */
// status led blink controller top level: input register, activity checks,
// led sequencer and result register; depends on slbc_pkg, slbc_activity,
// slbc_led_sequencer
//
// usage: one input item per status tick (current time, last receive time of
// three satellites, flight mode, binding and imu ready flags). each item gives
// exactly one result item with the satellite leds, status led levels and the
// failsafe request and flag.
// channels use valid/stall; an item moves on an edge with valid high and
// stall low. the item is captured in an input register, the leds are worked
// out from it combinationally and land in the result register, where
// out_valid shows them until the receiver takes them. throughput is one
// item per cycle, limited only by the result register: while the receiver
// stalls a finished result, one more item is still taken into the input
// register, after which in_stall rises until the result goes.
// configuration (activity window, receive only) is written through
// cfg_write/cfg_index/cfg_data; the user must write it only while no item
// is in flight, since the block itself does not enforce this.
// reset clears both registers' valid flags, the blink phase, the led levels
// and the failsafe flag, and loads the configuration reset values.
module status_led_blink_controller #(
  parameter int TIME_WIDTH = slbc_pkg::TIME_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [slbc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [slbc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [TIME_WIDTH-1:0]                current_time,
  input  logic [TIME_WIDTH-1:0]                last_rx_sat1,
  input  logic [TIME_WIDTH-1:0]                last_rx_sat2,
  input  logic [TIME_WIDTH-1:0]                last_rx_sat3,
  input  logic [slbc_pkg::MODE_WIDTH-1:0]      flight_mode,
  input  logic                                 binding,
  input  logic                                 imu_ready,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 sat1_led,
  output logic                                 sat2_led,
  output logic                                 sat3_led,
  output logic                                 status_led_a,
  output logic                                 status_led_b,
  output logic                                 failsafe_request,
  output logic                                 failsafe_active
);
  import slbc_pkg::*;

  logic [WINDOW_WIDTH-1:0] activity_window;
  logic                    receive_only;

  logic                    hold_valid;
  logic [TIME_WIDTH-1:0]   hold_now;
  logic [TIME_WIDTH-1:0]   hold_last [NUM_SATS];
  logic [MODE_WIDTH-1:0]   hold_mode;
  logic                    hold_binding;
  logic                    hold_imu_ready;

  logic                    in_take;
  logic                    result_load;
  logic [NUM_SATS-1:0]     sat_active;
  tick_ctl_t               ctl;
  led_result_t             result;

  always_ff @(posedge clk) begin
    if (rst) begin
      activity_window <= ACTIVITY_WINDOW_RESET;
      receive_only    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ACTIVITY_WINDOW: activity_window <= cfg_data;
        REG_RECEIVE_ONLY:    receive_only    <= cfg_data[0];
        default:             ;
      endcase
    end
  end

  assign result_load = hold_valid && (!out_valid || !out_stall);
  assign in_stall    = hold_valid && out_valid && out_stall;
  assign in_take     = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_take) begin
      hold_valid <= 1'b1;
    end else if (result_load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_now       <= current_time;
      hold_last[0]   <= last_rx_sat1;
      hold_last[1]   <= last_rx_sat2;
      hold_last[2]   <= last_rx_sat3;
      hold_mode      <= flight_mode;
      hold_binding   <= binding;
      hold_imu_ready <= imu_ready;
    end
  end

  for (genvar s = 0; s < NUM_SATS; s++) begin : g_sat
    slbc_activity #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_activity (
      .now    (hold_now),
      .last   (hold_last[s]),
      .window (activity_window),
      .active (sat_active[s])
    );
  end

  assign ctl.any_active   = |sat_active;
  assign ctl.mode         = hold_mode;
  assign ctl.binding      = hold_binding;
  assign ctl.imu_ready    = hold_imu_ready;
  assign ctl.receive_only = receive_only;

  slbc_led_sequencer u_sequencer (
    .clk     (clk),
    .rst     (rst),
    .advance (result_load),
    .ctl     (ctl),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      sat1_led         <= sat_active[0];
      sat2_led         <= sat_active[1];
      sat3_led         <= sat_active[2];
      status_led_a     <= result.led_a;
      status_led_b     <= result.led_b;
      failsafe_request <= result.request;
      failsafe_active  <= result.failsafe;
    end
  end

endmodule

/* rtl/slbc_checker.sv */
// port-level checks for the status led blink controller, bound to the top
// depends on status_led_blink_controller only through its ports
module slbc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic sat1_led,
  input logic sat2_led,
  input logic sat3_led,
  input logic status_led_a,
  input logic status_led_b,
  input logic failsafe_request,
  input logic failsafe_active
);

  // a request only on a tick with the flag set and no satellite heard
  assert property (@(posedge clk) disable iff (rst)
    out_valid && failsafe_request |-> failsafe_active &&
      !sat1_led && !sat2_led && !sat3_led)
    else $error("failsafe request without engaged flag or with live satellite");

  // any live satellite clears the failsafe flag
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (sat1_led || sat2_led || sat3_led) |-> !failsafe_active)
    else $error("failsafe flag set with an active satellite");

  // nothing in flight right after reset
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({sat1_led, sat2_led, sat3_led, status_led_a, status_led_b,
               failsafe_request, failsafe_active}))
    else $error("stalled result changed");

  // input side stalls only while a result waits on a stalled receiver
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result register");

endmodule

bind status_led_blink_controller slbc_checker u_slbc_checker (.*);
